### src/weighted_relaxation_update_defines.svh
// Assertion macros used by the checker file of the relaxation block.
`ifndef WEIGHTED_RELAXATION_UPDATE_DEFINES_SVH
`define WEIGHTED_RELAXATION_UPDATE_DEFINES_SVH

// Concurrent assertion that is switched off while reset is high.
`define WRU_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also holds through reset.
`define WRU_ASSERT_ANY(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/wru_pkg.sv
// Types and constants of the weighted relaxation update block.
package wru_pkg;

   localparam int TEMP_W     = 32;
   localparam int WGT_W      = 16;
   localparam int PERIM_W    = 18;
   localparam int RATE_W     = 17;
   localparam int SUM_W      = 64;
   localparam int STEP_W     = 42;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = RATE_W;
   localparam int DIV_CNT_W  = 6;

   // Shared multiplier: signed 33 by signed 18.
   localparam int MUL_A_W = TEMP_W + 1;
   localparam int MUL_B_W = RATE_W + 1;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   localparam logic [CSR_IDX_W-1:0] REG_AFFECT_RATE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_EPSILON     = 4'd1;

   localparam logic [RATE_W-1:0] AFFECT_RATE_RESET = 17'd65536;
   localparam logic [RATE_W-1:0] EPSILON_RESET     = 17'd655;

   localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   localparam logic signed [SUM_W:0] LIM62_POS = 65'sd1 <<< 62;
   localparam logic signed [SUM_W:0] LIM62_NEG = -LIM62_POS;

   localparam logic signed [65:0] LIM40_POS = 66'sd1 <<< 40;
   localparam logic signed [65:0] LIM40_NEG = -LIM40_POS;

   localparam logic signed [STEP_W:0] TEMP_POS = 43'sd2147483647;
   localparam logic signed [STEP_W:0] TEMP_NEG = -43'sd2147483648;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_DSTART,
      ST_DIV,
      ST_AVG,
      ST_DIFF,
      ST_MLO,
      ST_MHI,
      ST_STEP,
      ST_NEW,
      ST_UPD,
      ST_TOL,
      ST_CONV,
      ST_FIN
   } wru_state_type;

endpackage

### src/wru_if.sv
// Handshake channels of the relaxation block: terms in, results out, register writes.
interface wru_req_if;
   import wru_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [TEMP_W-1:0]   term_value;
   logic        [WGT_W-1:0]    term_weight;
   logic        [PERIM_W-1:0]  perimeter;
   logic                       first_term;
   logic                       last_term;
   logic                       last_cell;

   modport source (output valid, term_value, term_weight, perimeter, first_term,
                   last_term, last_cell, input ready);
   modport sink (input valid, term_value, term_weight, perimeter, first_term,
                 last_term, last_cell, output ready);
   modport monitor (input valid, ready, term_value, term_weight, perimeter,
                    first_term, last_term, last_cell);
endinterface

interface wru_rsp_if;
   import wru_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] new_temp;
   logic signed [TEMP_W-1:0] pass_max;
   logic signed [TEMP_W-1:0] pass_min;
   logic                     pass_done;
   logic                     converged;

   modport source (output valid, new_temp, pass_max, pass_min, pass_done, converged,
                   input ready);
   modport sink (input valid, new_temp, pass_max, pass_min, pass_done, converged,
                 output ready);
   modport monitor (input valid, ready, new_temp, pass_max, pass_min, pass_done,
                    converged);
endinterface

interface wru_csr_if;
   import wru_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
   modport monitor (input valid, ready, index, data);
endinterface

### src/weighted_relaxation_update.sv
// Weighted relaxation update: accumulates weighted terms per cell and relaxes toward the average.
//
//   channel   dir   handshake        carries
//   req_bus   in    valid / ready    one weighted term per item
//   rsp_bus   out   valid / ready    new temperature, pass min/max, pass flags
//   csr_bus   in    valid / ready    register index and write data, always ready
//
// A term that does not end a cell passes through accept, multiply and accumulate.
// A term that ends a cell then runs the one-bit-per-cycle divider, the relaxation step
// and, when it also ends the pass, the tolerance check. A zero perimeter skips the divider and the step.
// Synchronous reset returns the sequencer to idle and restores the register defaults.
// A finished result waits in the output register; the sequencer stalls only when
// a new result is ready while the previous one has not yet been taken.
module weighted_relaxation_update (
   input logic        clock,
   input logic        reset,
   wru_req_if.sink    req_bus,
   wru_rsp_if.source  rsp_bus,
   wru_csr_if.sink    csr_bus
);
   import wru_pkg::*;

   wru_state_type state_ff, state_in;

   logic [RATE_W-1:0] rate_ff, eps_ff;

   logic signed [TEMP_W-1:0]  val_ff;
   logic        [WGT_W-1:0]   wgt_ff;
   logic                      first_ff, last_ff, lastc_ff;
   logic signed [TEMP_W-1:0]  own_ff;
   logic        [PERIM_W-1:0] perim_ff;

   logic [SUM_W-1:0] sum_ff, sum_in;
   logic signed [MUL_P_W-1:0] prod_ff, prod_in;
   logic [MUL_P_W-3:0] lo_ff, lo_in;

   logic [SUM_W-1:0]     quo_ff, quo_in;
   logic [PERIM_W-1:0]   rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 neg_ff, neg_in;

   logic [SUM_W-1:0]        avg_ff, avg_in;
   logic [SUM_W-1:0]        diff_ff, diff_in;
   logic signed [STEP_W-1:0] step_ff, step_in;
   logic signed [TEMP_W-1:0] nt_ff, nt_in;

   logic signed [TEMP_W-1:0] max_ff, max_in, min_ff, min_in;
   logic                     started_ff, started_in;
   logic                     done_ff, done_in, conv_ff, conv_in;

   logic                     rsp_valid_ff;
   logic signed [TEMP_W-1:0] out_nt_ff, out_max_ff, out_min_ff;
   logic                     out_done_ff, out_conv_ff;

   // Shared multiplier operands and product.
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] mul_p;

   logic req_ready, req_take, out_free, out_load;

   logic [SUM_W-1:0]   term_ext;
   logic [SUM_W:0]     acc_wide;
   logic [PERIM_W:0]   div_shift;
   logic [PERIM_W+1:0] div_trial;
   logic               div_fit;
   logic               quo_big;
   logic [SUM_W-1:0]   quo_neg;
   logic signed [SUM_W:0] diff_wide;
   logic signed [65:0]    step_raw;
   logic signed [STEP_W:0] nt_wide;
   logic signed [TEMP_W:0] spread;
   logic signed [MUL_P_W-1:0] spread_q;

   assign mul_p = mul_a * mul_b;

   assign req_take = req_bus.valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign out_load = (state_ff == ST_FIN) && out_free;

   // Accumulation with 64-bit saturation.
   assign term_ext = {{(SUM_W-MUL_P_W){prod_ff[MUL_P_W-1]}}, prod_ff};
   assign acc_wide = {sum_ff[SUM_W-1], sum_ff} + {term_ext[SUM_W-1], term_ext};

   // One restoring division step on the magnitude of the sum.
   assign div_shift = {rem_ff, quo_ff[SUM_W-1]};
   assign div_trial = {1'b0, div_shift} - {2'b00, perim_ff};
   assign div_fit   = !div_trial[PERIM_W+1];

   assign quo_big = quo_ff[SUM_W-1] | (quo_ff[SUM_W-2] & (|quo_ff[SUM_W-3:0]));
   assign quo_neg = -quo_ff;

   assign diff_wide = $signed({{(SUM_W-TEMP_W+1){own_ff[TEMP_W-1]}}, own_ff})
                    - $signed({avg_ff[SUM_W-1], avg_ff});

   // floor(diff * rate / 2^16) from the high and low partial products.
   assign step_raw = $signed({prod_ff[48], prod_ff[48:0], 16'b0})
                   + $signed({33'b0, lo_ff[48:16]});

   assign nt_wide = $signed({{(STEP_W-TEMP_W+1){own_ff[TEMP_W-1]}}, own_ff})
                  - $signed({step_ff[STEP_W-1], step_ff});

   assign spread   = $signed({max_ff[TEMP_W-1], max_ff}) - $signed({min_ff[TEMP_W-1], min_ff});
   assign spread_q = $signed({{(MUL_P_W-TEMP_W-17){spread[TEMP_W]}}, spread, 16'b0});

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) state_in = ST_MUL;
         end
         ST_MUL: state_in = ST_ACC;
         ST_ACC: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (perim_ff == '0) begin
               state_in = ST_UPD;
            end else begin
               state_in = ST_DSTART;
            end
         end
         ST_DSTART: state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == '1) state_in = ST_AVG;
         end
         ST_AVG:  state_in = ST_DIFF;
         ST_DIFF: state_in = ST_MLO;
         ST_MLO:  state_in = ST_MHI;
         ST_MHI:  state_in = ST_STEP;
         ST_STEP: state_in = ST_NEW;
         ST_NEW:  state_in = ST_UPD;
         ST_UPD:  state_in = lastc_ff ? ST_TOL : ST_FIN;
         ST_TOL:  state_in = ST_CONV;
         ST_CONV: state_in = ST_FIN;
         ST_FIN: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: input ready and multiplier operand selection.
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      mul_a     = '0;
      mul_b     = '0;
      case (state_ff)
         ST_MUL: begin
            mul_a = {val_ff[TEMP_W-1], val_ff};
            mul_b = {2'b00, wgt_ff};
         end
         ST_MLO: begin
            mul_a = {1'b0, diff_ff[TEMP_W-1:0]};
            mul_b = {1'b0, rate_ff};
         end
         ST_MHI: begin
            mul_a = {diff_ff[SUM_W-1], diff_ff[SUM_W-1:TEMP_W]};
            mul_b = {1'b0, rate_ff};
         end
         ST_TOL: begin
            mul_a = {max_ff[TEMP_W-1], max_ff};
            mul_b = {1'b0, eps_ff};
         end
         default: begin
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      sum_in     = sum_ff;
      prod_in    = prod_ff;
      lo_in      = lo_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      cnt_in     = cnt_ff;
      neg_in     = neg_ff;
      avg_in     = avg_ff;
      diff_in    = diff_ff;
      step_in    = step_ff;
      nt_in      = nt_ff;
      max_in     = max_ff;
      min_in     = min_ff;
      started_in = started_ff;
      done_in    = done_ff;
      conv_in    = conv_ff;
      case (state_ff)
         ST_MUL: prod_in = mul_p;
         ST_ACC: begin
            if (first_ff) begin
               sum_in = term_ext;
            end else if (acc_wide[SUM_W] != acc_wide[SUM_W-1]) begin
               sum_in = acc_wide[SUM_W] ? SUM_MIN : SUM_MAX;
            end else begin
               sum_in = acc_wide[SUM_W-1:0];
            end
            nt_in = own_ff;
         end
         ST_DSTART: begin
            neg_in = sum_ff[SUM_W-1];
            quo_in = sum_ff[SUM_W-1] ? -sum_ff : sum_ff;
            rem_in = '0;
            cnt_in = '0;
         end
         ST_DIV: begin
            rem_in = div_fit ? div_trial[PERIM_W-1:0] : div_shift[PERIM_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], div_fit};
            cnt_in = cnt_ff + 1'b1;
         end
         ST_AVG: begin
            if (quo_big) begin
               avg_in = neg_ff ? LIM62_NEG[SUM_W-1:0] : LIM62_POS[SUM_W-1:0];
            end else begin
               avg_in = neg_ff ? quo_neg : quo_ff;
            end
         end
         ST_DIFF: begin
            if (diff_wide > LIM62_POS) begin
               diff_in = LIM62_POS[SUM_W-1:0];
            end else if (diff_wide < LIM62_NEG) begin
               diff_in = LIM62_NEG[SUM_W-1:0];
            end else begin
               diff_in = diff_wide[SUM_W-1:0];
            end
         end
         ST_MLO: lo_in   = mul_p[MUL_P_W-3:0];
         ST_MHI: prod_in = mul_p;
         ST_STEP: begin
            if (step_raw > LIM40_POS) begin
               step_in = LIM40_POS[STEP_W-1:0];
            end else if (step_raw < LIM40_NEG) begin
               step_in = LIM40_NEG[STEP_W-1:0];
            end else begin
               step_in = step_raw[STEP_W-1:0];
            end
         end
         ST_NEW: begin
            if (nt_wide > TEMP_POS) begin
               nt_in = TEMP_POS[TEMP_W-1:0];
            end else if (nt_wide < TEMP_NEG) begin
               nt_in = TEMP_NEG[TEMP_W-1:0];
            end else begin
               nt_in = nt_wide[TEMP_W-1:0];
            end
         end
         ST_UPD: begin
            sum_in = '0;
            if (!started_ff) begin
               max_in = nt_ff;
               min_in = nt_ff;
            end else begin
               if (nt_ff > max_ff) max_in = nt_ff;
               if (nt_ff < min_ff) min_in = nt_ff;
            end
            started_in = !lastc_ff;
            done_in    = lastc_ff;
            conv_in    = 1'b0;
         end
         ST_TOL:  prod_in = mul_p;
         ST_CONV: conv_in = (spread_q <= prod_ff);
         default: begin
         end
      endcase
   end

   // Control state and the registers that have a reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rate_ff      <= AFFECT_RATE_RESET;
         eps_ff       <= EPSILON_RESET;
         sum_ff       <= '0;
         own_ff       <= '0;
         perim_ff     <= '0;
         max_ff       <= '0;
         min_ff       <= '0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         sum_ff     <= sum_in;
         max_ff     <= max_in;
         min_ff     <= min_in;
         started_ff <= started_in;
         if (csr_bus.valid) begin
            if (csr_bus.index == REG_AFFECT_RATE) rate_ff <= csr_bus.data;
            if (csr_bus.index == REG_EPSILON) eps_ff <= csr_bus.data;
         end
         if (req_take && req_bus.first_term) begin
            own_ff   <= req_bus.term_value;
            perim_ff <= req_bus.perimeter;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         val_ff   <= req_bus.term_value;
         wgt_ff   <= req_bus.term_weight;
         first_ff <= req_bus.first_term;
         last_ff  <= req_bus.last_term;
         lastc_ff <= req_bus.last_cell;
      end
      prod_ff <= prod_in;
      lo_ff   <= lo_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      avg_ff  <= avg_in;
      diff_ff <= diff_in;
      step_ff <= step_in;
      nt_ff   <= nt_in;
      done_ff <= done_in;
      conv_ff <= conv_in;
      if (out_load) begin
         out_nt_ff   <= nt_ff;
         out_max_ff  <= max_ff;
         out_min_ff  <= min_ff;
         out_done_ff <= done_ff;
         out_conv_ff <= conv_ff;
      end
   end

   assign req_bus.ready     = req_ready;
   assign csr_bus.ready     = 1'b1;
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.new_temp  = out_nt_ff;
   assign rsp_bus.pass_max  = out_max_ff;
   assign rsp_bus.pass_min  = out_min_ff;
   assign rsp_bus.pass_done = out_done_ff;
   assign rsp_bus.converged = out_conv_ff;

endmodule

### src/wru_checker.sv
// Port-level checks of the relaxation block, bound to its top level.
`include "weighted_relaxation_update_defines.svh"

module wru_checker (
   input logic       clock,
   input logic       reset,
   wru_req_if.sink   req_bus,
   wru_rsp_if.source rsp_bus
);

   // Once a term is taken, ready drops while the sequencer works on it.
   `WRU_ASSERT_RST(a_busy_after_take, clock, reset, req_bus.valid && req_bus.ready |=> !req_bus.ready, "ready stayed high after an item was taken")

   // The convergence flag only comes with the end of a pass.
   `WRU_ASSERT_RST(a_conv_with_done, clock, reset, rsp_bus.valid |-> (!rsp_bus.converged || rsp_bus.pass_done), "converged set without pass_done")

   // The reported range always contains the new temperature.
   `WRU_ASSERT_RST(a_temp_in_range, clock, reset, rsp_bus.valid |-> (rsp_bus.pass_min <= rsp_bus.new_temp) && (rsp_bus.new_temp <= rsp_bus.pass_max), "new_temp outside pass_min and pass_max")

   // Reset leaves the block idle and ready.
   `WRU_ASSERT_ANY(a_ready_after_reset, clock, reset |=> req_bus.ready, "block not ready after reset")

endmodule

bind weighted_relaxation_update wru_checker u_wru_checker (
   .clock   (clock),
   .reset   (reset),
   .req_bus (req_bus),
   .rsp_bus (rsp_bus)
);
